// File: rtl/besp_pkg.sv
// Shared constants, codes and types of the big-endian scratchpad port.
`default_nettype none

package besp_pkg;

  // Default size of each of the two memories, in bytes
  localparam int MEM_BYTES_DEF    = 4096;
  // Widest access; wider requests saturate to this
  localparam int MAX_ACCESS_BYTES = 8;

  // Byte banks; an access of up to eight bytes touches each bank at most once
  localparam int NUM_BANKS = 8;
  localparam int LANE_W    = 3;
  localparam int BYTE_W    = 8;

  // Payload field widths
  localparam int CMD_W   = 2;
  localparam int ADDR_W  = 13;
  localparam int SIZE_W  = 4;
  localparam int DATA_W  = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_HOST_READ  = 2'd0,
    CMD_HOST_WRITE = 2'd1,
    CMD_COP_READ   = 2'd2,
    CMD_COP_WRITE  = 2'd3
  } cmd_t;

  // What the read assembly needs to know about an issued access
  typedef struct packed {
    logic [LANE_W-1:0] lane;   // bank of the first (most significant) byte
    logic [SIZE_W-1:0] size;   // saturated access width in bytes
    logic              write;  // access was a write: result is zero
  } rd_meta_t;

  // Saturate a byte count to a limit
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] value,
                                                   input logic [SIZE_W-1:0] limit);
    clamp_size = (value > limit) ? limit : value;
  endfunction

endpackage

`default_nettype wire

// File: rtl/besp_if.sv
// Request and response channel interfaces of the scratchpad port.
`default_nettype none

interface besp_req_if
  import besp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;
  logic [SIZE_W-1:0] access_bytes;
  logic [SIZE_W-1:0] write_count;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, command, address, access_bytes, write_count, write_data,
                  input ready);
  modport sink   (input valid, command, address, access_bytes, write_count, write_data,
                  output ready);
endinterface

interface besp_rsp_if
  import besp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

// File: rtl/besp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module besp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register read data only when a read is issued
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/besp_lane_map.sv
// Request decode: memory select, wrapping bank rows and byte-lane write steering.
`default_nettype none

module besp_lane_map
  import besp_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic [SIZE_W-1:0] access_bytes,
  input  wire logic [SIZE_W-1:0] write_count,
  input  wire logic [DATA_W-1:0] write_data,
  output logic [$clog2(MEM_BYTES)-LANE_W:0] bank_addr [NUM_BANKS],
  output logic [NUM_BANKS-1:0]              bank_we,
  output logic [BYTE_W-1:0]                 bank_wdata [NUM_BANKS],
  output logic                              is_write,
  output rd_meta_t                          meta
);

  localparam int OFS_W = $clog2(MEM_BYTES);
  localparam int ROW_W = OFS_W - LANE_W;

  logic [OFS_W-1:0]  ofs;
  logic              sel_bit;
  logic              host;
  logic              sel;
  logic [LANE_W-1:0] lane;
  logic [ROW_W-1:0]  row;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] count;

  // Byte offset inside one memory, and the bit above it that picks the memory
  if (OFS_W < ADDR_W) begin : g_split
    assign ofs     = address[OFS_W-1:0];
    assign sel_bit = address[OFS_W];
  end else begin : g_wide
    assign ofs     = OFS_W'(address);
    assign sel_bit = 1'b0;
  end

  // Decode the command
  always_comb begin
    unique case (cmd_t'(command))
      CMD_HOST_READ: begin
        host     = 1'b1;
        is_write = 1'b0;
      end
      CMD_HOST_WRITE: begin
        host     = 1'b1;
        is_write = 1'b1;
      end
      CMD_COP_READ: begin
        host     = 1'b0;
        is_write = 1'b0;
      end
      CMD_COP_WRITE: begin
        host     = 1'b0;
        is_write = 1'b1;
      end
      default: begin
        host     = 1'b0;
        is_write = 1'b0;
      end
    endcase
  end

  // Coprocessor accesses always go to data memory
  assign sel   = host & sel_bit;
  assign lane  = ofs[LANE_W-1:0];
  assign row   = ofs[OFS_W-1:LANE_W];
  assign size  = clamp_size(access_bytes, SIZE_W'(MAX_ACCESS_BYTES));
  assign count = clamp_size(write_count, size);

  assign meta.lane  = lane;
  assign meta.size  = size;
  assign meta.write = is_write;

  // Per bank: row of the byte it holds, and which operand byte goes there
  always_comb begin
    logic [LANE_W-1:0] idx;
    logic [SIZE_W-1:0] shift;
    for (int b = 0; b < NUM_BANKS; b++) begin
      idx   = LANE_W'(b) - lane;
      shift = size - SIZE_W'(idx) - SIZE_W'(1);
      // Banks below the first lane hold bytes of the next row, wrapping at the end
      bank_addr[b]  = {sel, row + ROW_W'(LANE_W'(b) < lane)};
      bank_we[b]    = is_write && (SIZE_W'(idx) < count);
      bank_wdata[b] = write_data[BYTE_W*shift[LANE_W-1:0] +: BYTE_W];
    end
  end

endmodule

`default_nettype wire

// File: rtl/besp_read_align.sv
// Read assembly: gather bank bytes into a right-aligned big-endian value.
`default_nettype none

module besp_read_align
  import besp_pkg::*;
(
  input  wire rd_meta_t          meta,
  input  wire logic [BYTE_W-1:0] bank_rdata [NUM_BANKS],
  output logic [DATA_W-1:0]      value
);

  // Result byte p (from the bottom) is access byte size-1-p
  always_comb begin
    logic [SIZE_W-1:0] k;
    logic [LANE_W-1:0] bank;
    value = '0;
    for (int p = 0; p < NUM_BANKS; p++) begin
      k    = meta.size - SIZE_W'(p) - SIZE_W'(1);
      bank = meta.lane + k[LANE_W-1:0];
      if (!meta.write && (SIZE_W'(p) < meta.size)) begin
        value[BYTE_W*p +: BYTE_W] = bank_rdata[bank];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/big_endian_scratchpad_port.sv
// Top level of the big-endian byte-addressed scratchpad port.
//
//  Channel  Dir  Payload                                              Transfer
//  req      in   command, address, access_bytes, write_count,        valid & ready
//                write_data
//  rsp      out  read_data                                            valid & ready
//
// One access per cycle when rsp is taken; each result goes from its request transfer
// through the bank RAM read register, then the output register.
// Both memories live in eight byte-wide bank RAMs, so any access of up to eight
// bytes, aligned or not, reads or writes each bank at most once.
// rst clears only the pipeline valid flags; memory contents are undefined until written.
// A stalled rsp holds the waiting result in the output register and the access behind
// it in the RAM read register, then backs up req.
`default_nettype none

module big_endian_scratchpad_port
  import besp_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  besp_req_if.sink   req,
  besp_rsp_if.source rsp
);

  localparam int RAM_AW    = $clog2(MEM_BYTES) - LANE_W + 1;
  localparam int RAM_DEPTH = 2 * MEM_BYTES / NUM_BANKS;

  logic [RAM_AW-1:0]    bank_addr  [NUM_BANKS];
  logic [NUM_BANKS-1:0] bank_we;
  logic [BYTE_W-1:0]    bank_wdata [NUM_BANKS];
  logic [BYTE_W-1:0]    bank_rdata [NUM_BANKS];
  logic                 is_write;
  rd_meta_t             req_meta;
  logic                 in_fire;

  logic                 pend_valid;
  rd_meta_t             pend_meta;
  logic                 pend_move;
  logic [DATA_W-1:0]    pend_value;

  logic                 out_valid;
  logic [DATA_W-1:0]    out_data;

  // Decode the request onto the banks
  besp_lane_map #(
    .MEM_BYTES (MEM_BYTES)
  ) u_lane_map (
    .command      (req.command),
    .address      (req.address),
    .access_bytes (req.access_bytes),
    .write_count  (req.write_count),
    .write_data   (req.write_data),
    .bank_addr    (bank_addr),
    .bank_we      (bank_we),
    .bank_wdata   (bank_wdata),
    .is_write     (is_write),
    .meta         (req_meta)
  );

  // Byte banks; a write lands at the edge before any later read samples it
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    besp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (in_fire & bank_we[b]),
      .waddr (bank_addr[b]),
      .wdata (bank_wdata[b]),
      .re    (in_fire & ~is_write),
      .raddr (bank_addr[b]),
      .rdata (bank_rdata[b])
    );
  end

  // Advance the RAM stage when the output register is free or being drained
  assign pend_move = pend_valid && (!out_valid || rsp.ready);
  assign req.ready = !pend_valid || pend_move;
  assign in_fire   = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_fire) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_meta <= req_meta;
    end
  end

  // Assemble the big-endian result from the bank read data
  besp_read_align u_read_align (
    .meta       (pend_meta),
    .bank_rdata (bank_rdata),
    .value      (pend_value)
  );

  // Output register: load on advance, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_data <= pend_value;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

  // A read never writes a bank
  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !is_write) |-> (bank_we == '0))
    else $error("read access enabled a bank write");

  // A write stores no more bytes than requested
  a_write_count: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> ($countones(bank_we) <= int'(req.write_count)))
    else $error("write stored more bytes than write_count");

  // An accepted access occupies the RAM stage next cycle
  a_pend_load: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> pend_valid)
    else $error("accepted access lost before the RAM stage");

  // A write returns zero
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (pend_move && pend_meta.write) |=> (out_valid && (out_data == '0)))
    else $error("write returned nonzero data");

endmodule

`default_nettype wire

// File: tb/big_endian_scratchpad_port_test.sv
// Self-checking testbench for the big-endian scratchpad port: directed and random accesses.
`timescale 1ns / 100ps

module big_endian_scratchpad_port_test;
  import besp_pkg::*;

  localparam int MEM_SIZE    = MEM_BYTES_DEF;
  localparam int ADDR_MASK   = MEM_SIZE - 1;
  localparam int SEL_DATA    = 0;
  localparam int SEL_INSTR   = 1;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  logic clk;
  logic rst;

  besp_req_if req_ch ();
  besp_rsp_if rsp_ch ();

  big_endian_scratchpad_port u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of both memories, plus which bytes hold known data
  logic [BYTE_W-1:0] shadow_mem   [0:1][0:MEM_SIZE-1];
  bit                shadow_known [0:1][0:MEM_SIZE-1];

  logic [DATA_W-1:0] expected_read_q [$];
  int                error_count;
  int                quiet_cycles;
  bit                sender_idle;
  bit                receiver_idle;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic bit is_write(input cmd_t cmd);
    return (cmd == CMD_HOST_WRITE) || (cmd == CMD_COP_WRITE);
  endfunction

  // Host port picks the memory by address bit 12; coprocessor always uses data
  function automatic int target_memory(input cmd_t cmd, input logic [ADDR_W-1:0] addr);
    if ((cmd == CMD_HOST_READ || cmd == CMD_HOST_WRITE) && (addr & MEM_SIZE) != 0)
      return SEL_INSTR;
    return SEL_DATA;
  endfunction

  function automatic int clamp_width(input logic [SIZE_W-1:0] ab);
    return (ab > MAX_ACCESS_BYTES) ? MAX_ACCESS_BYTES : int'(ab);
  endfunction

  // True when every byte that a read would touch has been written
  function automatic bit bytes_known(input cmd_t cmd, input logic [ADDR_W-1:0] addr,
                                     input logic [SIZE_W-1:0] ab);
    int sel;
    int i;
    sel = target_memory(cmd, addr);
    for (i = 0; i < clamp_width(ab); i++)
      if (!shadow_known[sel][(int'(addr) + i) & ADDR_MASK])
        return 1'b0;
    return 1'b1;
  endfunction

  // Apply one access to the shadow memories and return the expected read_data
  function automatic logic [DATA_W-1:0] scratchpad_apply(
      input cmd_t cmd, input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] ab,
      input logic [SIZE_W-1:0] wc, input logic [DATA_W-1:0] wd);
    int width;
    int count;
    int sel;
    int i;
    logic [DATA_W-1:0] value;
    width = clamp_width(ab);
    count = (wc > width) ? width : int'(wc);
    sel   = target_memory(cmd, addr);
    value = '0;
    if (is_write(cmd)) begin
      for (i = 0; i < count; i++) begin
        shadow_mem[sel][(int'(addr) + i) & ADDR_MASK]   = BYTE_W'(wd >> (8 * (width - 1 - i)));
        shadow_known[sel][(int'(addr) + i) & ADDR_MASK] = 1'b1;
      end
    end else begin
      for (i = 0; i < width; i++)
        value = (value << 8) | shadow_mem[sel][(int'(addr) + i) & ADDR_MASK];
    end
    return value;
  endfunction

  // Mostly no gap, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Cluster around the start, end and middle of memory so reads find written bytes
  function automatic logic [ADDR_W-1:0] pick_address();
    int off;
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 2))
        0:       off = $urandom_range(0, 47);
        1:       off = MEM_SIZE - 24 + $urandom_range(0, 47);
        default: off = MEM_SIZE / 2 - 24 + $urandom_range(0, 47);
      endcase
      return ADDR_W'(($urandom_range(0, 1) * MEM_SIZE) | (off & ADDR_MASK));
    end
    return ADDR_W'($urandom);
  endfunction

  task automatic report_mismatch(input logic [DATA_W-1:0] got, input logic [DATA_W-1:0] want);
    $display("%0t: read_data mismatch: got %h, expected %h", $realtime, got, want);
    error_count++;
  endtask

  // Drive one request and record its expected result at the transfer
  task automatic send_access(input cmd_t cmd, input logic [ADDR_W-1:0] addr,
                             input logic [SIZE_W-1:0] ab, input logic [SIZE_W-1:0] wc,
                             input logic [DATA_W-1:0] wd);
    int gap;
    gap = sender_idle ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        = 1'b1;
    req_ch.command      = cmd;
    req_ch.address      = addr;
    req_ch.access_bytes = ab;
    req_ch.write_count  = wc;
    req_ch.write_data   = wd;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_read_q.push_back(scratchpad_apply(cmd, addr, ab, wc, wd));
    @(negedge clk);
  endtask

  task automatic send_random_access();
    cmd_t cmd;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] ab;
    logic [SIZE_W-1:0] wc;
    int r;
    int tries;
    cmd = cmd_t'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < 70)      ab = SIZE_W'(1 << $urandom_range(0, 3));
    else if (r < 88) ab = SIZE_W'($urandom_range(0, 1) ? 2 * $urandom_range(1, 3) + 1 : 6);
    else if (r < 94) ab = '0;
    else             ab = SIZE_W'($urandom_range(9, 15));
    addr = pick_address();
    // Never read a byte that was not written; fall back to a write
    if (!is_write(cmd)) begin
      tries = 0;
      while (!bytes_known(cmd, addr, ab) && tries < 16) begin
        addr = pick_address();
        tries++;
      end
      if (!bytes_known(cmd, addr, ab))
        cmd = (cmd == CMD_HOST_READ) ? CMD_HOST_WRITE : CMD_COP_WRITE;
    end
    r = $urandom_range(0, 99);
    if (r < 60)      wc = SIZE_W'(clamp_width(ab));
    else if (r < 85) wc = SIZE_W'($urandom_range(0, clamp_width(ab)));
    else             wc = SIZE_W'($urandom_range(0, 15));
    send_access(cmd, addr, ab, wc, {$urandom, $urandom});
  endtask

  // Widths, wrap at the end of both memories, saturation and empty accesses
  task automatic test_directed_cases();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    send_access(CMD_HOST_WRITE, 13'h0000, 4'd8,  4'd8,  64'h0123_4567_89AB_CDEF);
    send_access(CMD_HOST_READ,  13'h0000, 4'd8,  4'd0,  64'h0);
    send_access(CMD_HOST_READ,  13'h0003, 4'd3,  4'd0,  64'h0);
    send_access(CMD_HOST_WRITE, 13'h1000, 4'd8,  4'd8,  64'hFFFF_FFFF_FFFF_FFFF);
    send_access(CMD_HOST_READ,  13'h1000, 4'd8,  4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(CMD_COP_WRITE,  13'h1FFC, 4'd8,  4'd8,  64'hFEDC_BA98_7654_3210);
    send_access(CMD_HOST_READ,  13'h0FFC, 4'd8,  4'd0,  64'h0);
    send_access(CMD_COP_READ,   13'h1FFE, 4'd4,  4'd0,  64'h0);
    send_access(CMD_HOST_WRITE, 13'h1FFE, 4'd4,  4'd4,  64'h0000_0000_A5A5_5A5A);
    send_access(CMD_HOST_READ,  13'h1FFE, 4'd4,  4'd0,  64'h0);
    send_access(CMD_HOST_READ,  13'h1000, 4'd8,  4'd0,  64'h0);
    send_access(CMD_COP_READ,   13'h0001, 4'd5,  4'd0,  64'h0);
    send_access(CMD_COP_READ,   13'h0002, 4'd6,  4'd0,  64'h0);
    send_access(CMD_HOST_READ,  13'h0000, 4'd7,  4'd0,  64'h0);
    send_access(CMD_HOST_READ,  13'h0000, 4'd15, 4'd0,  64'h0);
    send_access(CMD_COP_WRITE,  13'h0010, 4'd15, 4'd15, 64'h1122_3344_5566_7788);
    send_access(CMD_COP_READ,   13'h0010, 4'd8,  4'd0,  64'h0);
    send_access(CMD_HOST_READ,  13'h0123, 4'd0,  4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
    send_access(CMD_HOST_WRITE, 13'h0010, 4'd0,  4'd5,  64'hFFFF_FFFF_FFFF_FFFF);
    send_access(CMD_COP_WRITE,  13'h0010, 4'd4,  4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
    send_access(CMD_COP_WRITE,  13'h0010, 4'd2,  4'd15, 64'hFFFF_FFFF_FFFF_ABCD);
    send_access(CMD_HOST_READ,  13'h0010, 4'd8,  4'd0,  64'h0);
    send_access(CMD_HOST_WRITE, 13'h0020, 4'd8,  4'd3,  64'hAABB_CCDD_EEFF_0011);
    send_access(CMD_HOST_READ,  13'h0020, 4'd3,  4'd0,  64'h0);
    send_access(CMD_COP_WRITE,  13'h0000, 4'd1,  4'd1,  64'h0);
  endtask

  // Back-to-back traffic with both sides always ready
  task automatic test_streaming_traffic(input int count);
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    repeat (count) send_random_access();
  endtask

  // Random traffic with gaps on the request side and stalls on the response side
  task automatic test_gapped_traffic(input int count);
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    repeat (count) send_random_access();
  endtask

  // Drive response ready: one ready cycle, then a random stall when enabled
  initial begin
    int stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
        if (receiver_idle) stall_left = pick_gap();
      end
    end
  end

  // Check each response transfer and watch for a hung handshake
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_read_q.size() == 0) begin
          $display("%0t: unexpected response, read_data %h", $realtime, rsp_ch.read_data);
          error_count++;
        end else if (rsp_ch.read_data !== expected_read_q[0]) begin
          report_mismatch(rsp_ch.read_data, expected_read_q.pop_front());
        end else begin
          void'(expected_read_q.pop_front());
        end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("big_endian_scratchpad_port_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    error_count         = 0;
    quiet_cycles        = 0;
    sender_idle         = 1'b0;
    receiver_idle       = 1'b0;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.command      = CMD_HOST_READ;
    req_ch.address      = '0;
    req_ch.access_bytes = '0;
    req_ch.write_count  = '0;
    req_ch.write_data   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_streaming_traffic(400);
    test_gapped_traffic(1225);

    // Drain outstanding results, then allow for any stray response
    req_ch.valid = 1'b0;
    while (expected_read_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_read_q.size() == 0) begin
      $display("big_endian_scratchpad_port_test: done, clean");
    end else begin
      $display("big_endian_scratchpad_port_test: done, errors");
    end
    $finish;
  end

endmodule
